>>> hw/rtl/iac_pkg.sv
// Shared types and constants for the intruder alarm controller.
`timescale 1ns / 1ps

package iac_pkg;

    typedef enum logic [2:0] {
        MODE_DISARMED  = 3'd0,
        MODE_ARMING    = 3'd1,
        MODE_ARMED     = 3'd2,
        MODE_DISARMING = 3'd3,
        MODE_INTRUDER  = 3'd4
    } mode_t;

    localparam logic [1:0] LED_GREEN = 2'd0;
    localparam logic [1:0] LED_BLUE  = 2'd1;
    localparam logic [1:0] LED_RED   = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PW_DIGIT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PW_DIGIT1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PW_DIGIT2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PW_DIGIT3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_GAP   = 3'd5;

    typedef logic [7:0]  key_t;
    typedef logic [15:0] ticks_t;
    typedef key_t [3:0]  digits_t;

    localparam ticks_t COUNT_SAT     = 16'd65534;
    localparam ticks_t DELAY_RESET   = 16'd1200;
    localparam ticks_t KEY_GAP_RESET = 16'd1000;
    localparam digits_t DIGITS_RESET = {8'd52, 8'd51, 8'd50, 8'd49};

    // Password unit control from the mode logic
    typedef struct packed {
        logic check;    // key is checked this item
        logic restart;  // key gap exceeded: entry starts over
    } pw_ctl_t;

    // Next result computed by the mode logic
    typedef struct packed {
        mode_t mode;
        logic  sounder;
        logic  accepted;
    } result_t;

endpackage

>>> hw/rtl/iac_pw.sv
// Password key store, entry position and comparison.
`timescale 1ns / 1ps

module iac_pw #(
    parameter int PASSWORD_LENGTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  iac_pkg::pw_ctl_t ctl,
    input  iac_pkg::key_t    key,
    input  iac_pkg::digits_t digits,
    output logic             match
);

    localparam int PosW = (PASSWORD_LENGTH > 1) ? $clog2(PASSWORD_LENGTH) : 1;
    localparam logic [PosW-1:0] LAST_POS = PosW'(PASSWORD_LENGTH - 1);

    logic [PosW-1:0] pos_reg;
    logic [PosW-1:0] pos_next;
    logic [PosW-1:0] pos_eff;
    iac_pkg::key_t   keys_reg [PASSWORD_LENGTH];
    logic            complete;
    logic            all_ok;

    assign pos_eff  = ctl.restart ? '0 : pos_reg;
    assign complete = ctl.check && (pos_eff == LAST_POS);

    // Earlier positions come from the store; the last one is the key itself.
    always_comb
    begin
        all_ok = (key == digits[2'(PASSWORD_LENGTH - 1)]);
        for (int i = 0; i < PASSWORD_LENGTH - 1; i++)
        begin
            if (keys_reg[i] != digits[2'(i)])
            begin
                all_ok = 1'b0;
            end
        end
    end

    assign match = complete && all_ok;

    always_comb
    begin
        pos_next = pos_reg;
        if (ctl.check)
        begin
            pos_next = (pos_eff == LAST_POS) ? '0 : pos_eff + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && ctl.check)
        begin
            keys_reg[pos_eff] <= key;
        end
    end

endmodule

>>> hw/rtl/iac_ctrl.sv
// Mode state machine, tick counter, sensor latches and sounder.
`timescale 1ns / 1ps

module iac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              key_valid,
    input  logic [2:0]        window_hits,
    input  logic              door_hit,
    input  iac_pkg::ticks_t   delay_ticks,
    input  iac_pkg::ticks_t   key_gap_ticks,
    input  logic              pw_match,
    output iac_pkg::pw_ctl_t  pw_ctl,
    output iac_pkg::result_t  result
);

    iac_pkg::mode_t  mode_reg, mode_next;
    logic            ep_reg, ep_next;
    iac_pkg::ticks_t tc_reg, tc_next;
    logic [2:0]      wf_reg, wf_next;
    logic            df_reg, df_next;
    logic            phase_reg, phase_next;
    logic            snd_reg, snd_next;

    logic [2:0]      wf;
    logic            df;
    iac_pkg::ticks_t inc1;
    iac_pkg::ticks_t inc2;
    iac_pkg::ticks_t tc_base;
    logic            delay_hit;
    logic            check_en;
    logic            go;

    assign wf        = wf_reg | window_hits;
    assign df        = df_reg | door_hit;
    assign inc1      = (tc_reg < iac_pkg::COUNT_SAT) ? tc_reg + 16'd1 : tc_reg;
    assign inc2      = inc1 + 16'd1;  // inc1 exceeds 65534 only when tc_reg holds 65535
    assign delay_hit = inc2 > delay_ticks;

    always_comb
    begin
        mode_next  = mode_reg;
        tc_base    = inc1;
        wf_next    = wf;
        df_next    = df;
        phase_next = phase_reg;
        snd_next   = snd_reg;
        check_en   = 1'b0;
        go         = 1'b0;
        unique case (mode_reg)
            iac_pkg::MODE_ARMING:
            begin
                tc_base = inc2;
                if (delay_hit)
                begin
                    go = 1'b1;
                    mode_next = iac_pkg::MODE_ARMED;
                end
            end
            iac_pkg::MODE_ARMED:
            begin
                if (wf != 3'd0)
                begin
                    go = 1'b1;
                    mode_next = iac_pkg::MODE_INTRUDER;
                end
                else if (df)
                begin
                    go = 1'b1;
                    mode_next = iac_pkg::MODE_DISARMING;
                end
                else
                begin
                    check_en = 1'b1;
                    if (pw_match)
                    begin
                        go = 1'b1;
                        mode_next = iac_pkg::MODE_DISARMED;
                    end
                end
            end
            iac_pkg::MODE_DISARMING:
            begin
                tc_base = inc2;
                if (delay_hit || (wf != 3'd0))
                begin
                    go = 1'b1;
                    mode_next = iac_pkg::MODE_INTRUDER;
                end
                else
                begin
                    check_en = 1'b1;
                    if (pw_match)
                    begin
                        go = 1'b1;
                        mode_next = iac_pkg::MODE_DISARMED;
                    end
                end
            end
            iac_pkg::MODE_INTRUDER:
            begin
                phase_next = !phase_reg;
                snd_next   = !phase_reg;
                check_en   = 1'b1;
                if (pw_match)
                begin
                    go = 1'b1;
                    mode_next = iac_pkg::MODE_DISARMED;
                end
            end
            default:
            begin
                // disarmed, and any stray code falls back to it
                mode_next = iac_pkg::MODE_DISARMED;
                if (ep_reg)
                begin
                    wf_next = 3'd0;
                    df_next = 1'b0;
                end
                snd_next = 1'b1;
                check_en = 1'b1;
                if (pw_match)
                begin
                    go = 1'b1;
                    mode_next = iac_pkg::MODE_ARMING;
                end
            end
        endcase

        pw_ctl.check   = check_en && key_valid;
        pw_ctl.restart = tc_base > key_gap_ticks;

        if (go || (pw_ctl.check && pw_ctl.restart))
        begin
            tc_next = '0;
        end
        else
        begin
            tc_next = tc_base;
        end
        ep_next = go;

        result.mode     = mode_next;
        result.sounder  = snd_next;
        result.accepted = pw_match;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= iac_pkg::MODE_DISARMED;
            ep_reg    <= 1'b1;
            tc_reg    <= '0;
            wf_reg    <= '0;
            df_reg    <= 1'b0;
            phase_reg <= 1'b0;
            snd_reg   <= 1'b1;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            ep_reg    <= ep_next;
            tc_reg    <= tc_next;
            wf_reg    <= wf_next;
            df_reg    <= df_next;
            phase_reg <= phase_next;
            snd_reg   <= snd_next;
        end
    end

endmodule

>>> hw/rtl/intruder_alarm_controller.sv
// Top level of the intruder alarm controller.
`timescale 1ns / 1ps
//
// Usage:
//   Tick channel (tick_valid/tick_ready) carries one item per alarm tick: an
//   optional keypad key plus window and door sensor pulses. Result channel
//   (result_valid/result_ready) returns one item per tick: mode after the
//   tick, sounder pin (active low), LED color/blink and a password-accepted
//   flag.
//   Latency: a result is valid the cycle after its tick is accepted.
//   Throughput: one item per clock. All next-state logic sits between the
//   state registers and the result register, so tick_ready stays high
//   whenever the result register is empty or is being drained that cycle.
//   Stall: while a result waits for result_ready, the result register holds
//   and tick_ready drops, so no tick is lost.
//   Configuration: cfg_write/cfg_index/cfg_data write the four password
//   digits, the arm/disarm delay and the key gap; write only while idle.
//   Reset (rst_n low, async): disarmed, first-tick flag set, counter and
//   latches cleared, sounder off (high), registers to their defaults.
//
module intruder_alarm_controller #(
    parameter int PASSWORD_LENGTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_write,
    input  logic [iac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iac_pkg::CFG_DATA_W-1:0] cfg_data,
    // tick items
    input  logic                           tick_valid,
    output logic                           tick_ready,
    input  logic                           key_valid,
    input  logic [7:0]                     key_code,
    input  logic [2:0]                     window_hits,
    input  logic                           door_hit,
    // result items
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [2:0]                     alarm_state,
    output logic                           sounder_level,
    output logic [1:0]                     led_color,
    output logic                           led_blinking,
    output logic                           password_accepted
);

    // configuration registers
    iac_pkg::digits_t digits_reg;
    iac_pkg::ticks_t  delay_reg;
    iac_pkg::ticks_t  gap_reg;

    // result register
    logic             rv_reg;
    logic [2:0]       state_reg;
    logic             snd_reg;
    logic [1:0]       color_reg;
    logic             blink_reg;
    logic             acc_reg;

    logic             step;
    iac_pkg::pw_ctl_t pw_ctl;
    logic             pw_match;
    iac_pkg::result_t res;
    logic [1:0]       color_next;
    logic             blink_next;

    assign tick_ready = !rv_reg || result_ready;
    assign step       = tick_valid && tick_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg <= iac_pkg::DIGITS_RESET;
            delay_reg  <= iac_pkg::DELAY_RESET;
            gap_reg    <= iac_pkg::KEY_GAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                iac_pkg::CFG_PW_DIGIT0: digits_reg[0] <= cfg_data[7:0];
                iac_pkg::CFG_PW_DIGIT1: digits_reg[1] <= cfg_data[7:0];
                iac_pkg::CFG_PW_DIGIT2: digits_reg[2] <= cfg_data[7:0];
                iac_pkg::CFG_PW_DIGIT3: digits_reg[3] <= cfg_data[7:0];
                iac_pkg::CFG_DELAY:     delay_reg     <= cfg_data;
                iac_pkg::CFG_KEY_GAP:   gap_reg       <= cfg_data;
                default:
                begin
                    // unused indexes are ignored
                end
            endcase
        end
    end

    iac_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .key_valid     (key_valid),
        .window_hits   (window_hits),
        .door_hit      (door_hit),
        .delay_ticks   (delay_reg),
        .key_gap_ticks (gap_reg),
        .pw_match      (pw_match),
        .pw_ctl        (pw_ctl),
        .result        (res)
    );

    iac_pw #(
        .PASSWORD_LENGTH (PASSWORD_LENGTH)
    ) u_pw (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .ctl    (pw_ctl),
        .key    (key_code),
        .digits (digits_reg),
        .match  (pw_match)
    );

    // LED indication follows the mode after the tick
    always_comb
    begin
        unique case (res.mode)
            iac_pkg::MODE_DISARMED:
            begin
                color_next = iac_pkg::LED_GREEN;
                blink_next = 1'b0;
            end
            iac_pkg::MODE_ARMING,
            iac_pkg::MODE_DISARMING:
            begin
                color_next = iac_pkg::LED_BLUE;
                blink_next = 1'b1;
            end
            iac_pkg::MODE_ARMED:
            begin
                color_next = iac_pkg::LED_RED;
                blink_next = 1'b0;
            end
            default:
            begin
                color_next = iac_pkg::LED_RED;
                blink_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else if (step)
        begin
            rv_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            rv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            state_reg <= res.mode;
            snd_reg   <= res.sounder;
            color_reg <= color_next;
            blink_reg <= blink_next;
            acc_reg   <= res.accepted;
        end
    end

    assign result_valid      = rv_reg;
    assign alarm_state       = state_reg;
    assign sounder_level     = snd_reg;
    assign led_color         = color_reg;
    assign led_blinking      = blink_reg;
    assign password_accepted = acc_reg;

endmodule

>>> hw/rtl/iac_checker.sv
// Port-level assertions for the intruder alarm controller, bound to the top.
`timescale 1ns / 1ps

module iac_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       tick_valid,
    input logic       tick_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [2:0] alarm_state,
    input logic [1:0] led_color,
    input logic       password_accepted
);

    // empty result register never blocks a tick
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> tick_ready)
        else $error("tick_ready low with empty result register");

    // every accepted tick yields a result the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && tick_ready) |=> result_valid)
        else $error("accepted tick produced no result");

    // stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(alarm_state) && $stable(password_accepted)))
        else $error("stalled result changed");

    // a correct password only ever lands in disarmed or arming
    a_accept_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && password_accepted) |->
            (alarm_state == 3'(iac_pkg::MODE_DISARMED)
             || alarm_state == 3'(iac_pkg::MODE_ARMING)))
        else $error("password accepted in unexpected mode");

    // green LED exactly when disarmed
    a_led_green: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((led_color == iac_pkg::LED_GREEN)
             == (alarm_state == 3'(iac_pkg::MODE_DISARMED))))
        else $error("LED color does not match mode");

endmodule

bind intruder_alarm_controller iac_checker u_iac_checker (.*);
